// File: rtl/svflnf_pkg.sv
package svflnf_pkg;

    localparam int AXES      = 3;
    localparam int AXIS_IW   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SAMPLE_W  = 16;
    localparam int AXIS_W    = 2;
    localparam int COEF_W    = 32;
    localparam int STATE_W   = 48;
    localparam int FRAC      = 24;
    localparam int MOP_W     = STATE_W - FRAC + 1;
    localparam int PROD_W    = COEF_W + MOP_W;
    localparam int ACC_W     = PROD_W + 1;
    localparam int XQ_W      = SAMPLE_W + FRAC;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 3'd4;

    localparam logic signed [COEF_W-1:0] A1_RESET = 32'sh0100_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M1L,
        S_M1H,
        S_M2L,
        S_M2H,
        S_A2,
        S_SV1,
        S_M3L,
        S_M3H,
        S_A3,
        S_SV2,
        S_WB,
        S_M4H,
        S_A4,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_A1,
        A_A2,
        A_FREQ,
        A_WEIGHT
    } t_asel;

    typedef enum logic [1:0] {
        B_IC1,
        B_V3,
        B_V1
    } t_bsel;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_ADD,
        ACC_SUB,
        ACC_LOAD_IC2,
        ACC_LOAD_X
    } t_accop;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_LP,
        OUT_NOTCH
    } t_outsel;

    typedef struct packed {
        logic    capture;
        logic    mul_en;
        t_asel   a_sel;
        t_bsel   b_sel;
        logic    mul_hi;
        t_accop  acc_op;
        logic    save_v1;
        logic    save_v2;
        logic    write_back;
        logic    out_load;
        t_outsel out_sel;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic notch;
        logic out_free;
    } t_status;

    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v[ACC_W-1:STATE_W-1] == {(ACC_W-STATE_W+1){v[ACC_W-1]}}) begin
            r = v[STATE_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-FRAC-1:0] w;
        logic signed [SAMPLE_W-1:0]   r;
        w = v[ACC_W-1:FRAC];
        if (w[ACC_W-FRAC-1:SAMPLE_W-1] == {(ACC_W-FRAC-SAMPLE_W+1){w[ACC_W-FRAC-1]}}) begin
            r = w[SAMPLE_W-1:0];
        end else if (w[ACC_W-FRAC-1]) begin
            r = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: rtl/svflnf_ctrl.sv
module svflnf_ctrl
    import svflnf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        o_cmd.a_sel    = A_A1;
        o_cmd.b_sel    = B_IC1;
        o_cmd.acc_op   = ACC_NONE;
        o_cmd.out_sel  = OUT_ZERO;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_M1L;
                end
            end
            S_M1L: begin
                o_cmd.mul_en = 1'b1;
                n_state      = i_status.bad ? S_OUT : S_M1H;
            end
            S_M1H: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_M2L;
            end
            S_M2L: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_A2;
                o_cmd.b_sel  = B_V3;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_M2H;
            end
            S_M2H: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_A2;
                o_cmd.b_sel  = B_V3;
                o_cmd.mul_hi = 1'b1;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_A2;
            end
            S_A2: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_SV1;
            end
            S_SV1: begin
                o_cmd.save_v1 = 1'b1;
                o_cmd.acc_op  = ACC_LOAD_IC2;
                n_state       = S_M3L;
            end
            S_M3L: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_FREQ;
                o_cmd.b_sel  = B_V1;
                n_state      = S_M3H;
            end
            S_M3H: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_FREQ;
                o_cmd.b_sel  = B_V1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_A3;
            end
            S_A3: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = S_SV2;
            end
            S_SV2: begin
                o_cmd.save_v2 = 1'b1;
                o_cmd.acc_op  = ACC_LOAD_X;
                n_state       = S_WB;
            end
            S_WB: begin
                o_cmd.write_back = 1'b1;
                o_cmd.mul_en     = 1'b1;
                o_cmd.a_sel      = A_WEIGHT;
                o_cmd.b_sel      = B_V1;
                n_state          = i_status.notch ? S_M4H : S_OUT;
            end
            S_M4H: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.a_sel  = A_WEIGHT;
                o_cmd.b_sel  = B_V1;
                o_cmd.mul_hi = 1'b1;
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_A4;
            end
            S_A4: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_status.bad) begin
                    o_cmd.out_sel = OUT_ZERO;
                end else if (i_status.notch) begin
                    o_cmd.out_sel = OUT_NOTCH;
                end else begin
                    o_cmd.out_sel = OUT_LP;
                end
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/svflnf_datapath.sv
module svflnf_datapath
    import svflnf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COEF_W-1:0]          i_cfg_data,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [AXIS_W-1:0]          i_axis_sel,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic [AXIS_W-1:0]          o_axis_out,
    input  t_cmd                       i_cmd,
    output t_status                    o_status
);

    logic                       r_mode;
    logic signed [COEF_W-1:0]   r_coef_a1;
    logic signed [COEF_W-1:0]   r_coef_a2;
    logic signed [COEF_W-1:0]   r_coef_freq;
    logic signed [COEF_W-1:0]   r_notch_weight;

    logic signed [STATE_W-1:0]  r_integ_one [AXES];
    logic signed [STATE_W-1:0]  r_integ_two [AXES];

    logic signed [SAMPLE_W-1:0] r_x;
    logic [AXIS_W-1:0]          r_axis;
    logic                       r_bad;
    logic signed [STATE_W-1:0]  r_ic1;
    logic signed [STATE_W-1:0]  r_ic2;
    logic signed [STATE_W-1:0]  r_v3;
    logic signed [STATE_W-1:0]  r_v1;
    logic signed [STATE_W-1:0]  r_v2;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_prod_lo;
    logic signed [ACC_W-1:0]    r_acc;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic [AXIS_W-1:0]          r_out_axis;

    logic                       in_axis_ok;
    logic [AXIS_IW-1:0]         rd_idx;
    logic [AXIS_IW-1:0]         wr_idx;
    logic signed [STATE_W-1:0]  rd_ic1;
    logic signed [STATE_W-1:0]  rd_ic2;
    logic signed [XQ_W-1:0]     in_xq;
    logic signed [XQ_W-1:0]     cur_xq;
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [STATE_W-1:0]  mul_b48;
    logic signed [MOP_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [PROD_W-1:0]   prod_term;
    logic                       out_free;
    logic signed [SAMPLE_W-1:0] n_out_sample;

    assign in_axis_ok = (int'(i_axis_sel) < AXES);
    assign rd_idx     = AXIS_IW'(i_axis_sel);
    assign wr_idx     = AXIS_IW'(r_axis);
    assign rd_ic1     = in_axis_ok ? r_integ_one[rd_idx] : '0;
    assign rd_ic2     = in_axis_ok ? r_integ_two[rd_idx] : '0;
    assign in_xq      = {i_sample_in, {FRAC{1'b0}}};
    assign cur_xq     = {r_x, {FRAC{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_coef_a1      <= A1_RESET;
            r_coef_a2      <= '0;
            r_coef_freq    <= '0;
            r_notch_weight <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode         <= i_cfg_data[0];
                REG_A1:     r_coef_a1      <= i_cfg_data;
                REG_A2:     r_coef_a2      <= i_cfg_data;
                REG_FREQ:   r_coef_freq    <= i_cfg_data;
                REG_WEIGHT: r_notch_weight <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x    <= i_sample_in;
            r_axis <= i_axis_sel;
            r_ic1  <= rd_ic1;
            r_ic2  <= rd_ic2;
            r_v3   <= sat48(ACC_W'(in_xq) - ACC_W'(rd_ic2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bad <= 1'b0;
        end else if (i_cmd.capture) begin
            r_bad <= !in_axis_ok;
        end
    end

    always_comb begin
        case (i_cmd.a_sel)
            A_A1:     mul_a = r_coef_a1;
            A_A2:     mul_a = r_coef_a2;
            A_FREQ:   mul_a = r_coef_freq;
            A_WEIGHT: mul_a = r_notch_weight;
            default:  mul_a = r_coef_a1;
        endcase
        case (i_cmd.b_sel)
            B_IC1:   mul_b48 = r_ic1;
            B_V3:    mul_b48 = r_v3;
            B_V1:    mul_b48 = r_v1;
            default: mul_b48 = r_ic1;
        endcase
    end

    assign mul_b = i_cmd.mul_hi ? {mul_b48[STATE_W-1], mul_b48[STATE_W-1:FRAC]}
                                : {1'b0, mul_b48[FRAC-1:0]};
    assign mul_p = mul_a * mul_b;
    assign prod_term = r_prod_lo ? (r_prod >>> FRAC) : r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod    <= mul_p;
            r_prod_lo <= !i_cmd.mul_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else begin
            case (i_cmd.acc_op)
                ACC_ADD:      r_acc <= r_acc + ACC_W'(prod_term);
                ACC_SUB:      r_acc <= r_acc - ACC_W'(prod_term);
                ACC_LOAD_IC2: r_acc <= ACC_W'(r_ic2);
                ACC_LOAD_X:   r_acc <= ACC_W'(cur_xq);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_v1) begin
            r_v1 <= sat48(r_acc);
        end
        if (i_cmd.save_v2) begin
            r_v2 <= sat48(r_acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_integ_one[i] <= '0;
                r_integ_two[i] <= '0;
            end
        end else if (i_cmd.write_back && !r_bad) begin
            r_integ_one[wr_idx] <= sat48((ACC_W'(r_v1) <<< 1) - ACC_W'(r_ic1));
            r_integ_two[wr_idx] <= sat48((ACC_W'(r_v2) <<< 1) - ACC_W'(r_ic2));
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        case (i_cmd.out_sel)
            OUT_LP:    n_out_sample = sat_out(ACC_W'(r_v2));
            OUT_NOTCH: n_out_sample = sat_out(r_acc);
            default:   n_out_sample = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= n_out_sample;
            r_out_axis   <= r_axis;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_out_sample;
    assign o_axis_out        = r_out_axis;
    assign o_status.bad      = r_bad;
    assign o_status.notch    = r_mode;
    assign o_status.out_free = out_free;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("Result loaded while the previous one was still held.");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("Output became valid without a result load.");

    a_no_writeback_bad_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_back |-> !r_bad)
        else $error("State write-back issued for an out-of-range axis.");

    a_no_capture_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |-> !(i_cmd.mul_en || i_cmd.out_load || i_cmd.write_back))
        else $error("New beat captured while an item was still in progress.");
`endif

endmodule

// File: rtl/svf_lowpass_notch_filter_top.sv
// Channel  Signals                                       Direction
// in       i_in_valid, o_in_ready, i_sample_in, i_axis_sel  into block
// out      o_out_valid, i_out_ready, o_sample_out, o_axis_out  out of block
// cfg      i_cfg_we, i_cfg_index, i_cfg_data              into block, write only
//
// One shared 32x25 multiplier forms every coefficient product in two halves, so a beat
// is handled in steps; a notch result also subtracts a weighted term from the input.
// An out-of-range axis skips the arithmetic and loads a zero result instead.
// A new beat is accepted once the previous result sits in the output register.
// A stalled output holds the controller in its final state until the register frees.
// Reset is synchronous and active low; it clears the integrator states at once.
module svf_lowpass_notch_filter_top
    import svflnf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COEF_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic [AXIS_W-1:0]          i_axis_sel,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_sample_out,
    output logic [AXIS_W-1:0]          o_axis_out
);

    t_cmd    cmd;
    t_status status;

    svflnf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    svflnf_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_axis_sel   (i_axis_sel),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .o_axis_out   (o_axis_out),
        .i_cmd        (cmd),
        .o_status     (status)
    );

endmodule
